// File: rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
// Package for the radix-2 FFT core: widths, register indexes, state codes,
// twiddle table and helper functions. No dependencies.
package r2fft_pkg;

  localparam int unsigned LOG2_MAX_POINTS = 6;
  localparam int unsigned SAMPLE_WIDTH    = 16;
  localparam int unsigned WORD_WIDTH      = 24;
  localparam int unsigned DEPTH           = 1 << LOG2_MAX_POINTS;
  localparam int unsigned AW              = LOG2_MAX_POINTS;
  localparam int unsigned CFG_IDX_WIDTH   = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 3;
  localparam int unsigned LOG_WIDTH       = 3;
  localparam int unsigned COEF_WIDTH      = 17;
  localparam int unsigned PROD_WIDTH      = WORD_WIDTH + COEF_WIDTH + 1;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DIRECTION   = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOG2_POINTS = 1'b1;

  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = 24'sh7FFFFF;
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = -24'sh800000;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [AW-1:0]                addr_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_PERM  = 6'b000010,
    ST_BFLY  = 6'b000100,
    ST_EMIT  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_WR    = 6'b100000
  } state_e;

  function automatic coef_t quarter_cos(input logic [4:0] k);
    case (k)
      5'd0:  return 17'sd32768;
      5'd1:  return 17'sd32610;
      5'd2:  return 17'sd32138;
      5'd3:  return 17'sd31357;
      5'd4:  return 17'sd30273;
      5'd5:  return 17'sd28899;
      5'd6:  return 17'sd27246;
      5'd7:  return 17'sd25330;
      5'd8:  return 17'sd23170;
      5'd9:  return 17'sd20788;
      5'd10: return 17'sd18205;
      5'd11: return 17'sd15447;
      5'd12: return 17'sd12540;
      5'd13: return 17'sd9512;
      5'd14: return 17'sd6393;
      5'd15: return 17'sd3212;
      default: return 17'sd0;
    endcase
  endfunction

  function automatic coef_t cos64(input logic [4:0] k);
    return (k <= 5'd16) ? quarter_cos(k) : -quarter_cos(5'(6'd32 - {1'b0, k}));
  endfunction

  function automatic coef_t sin64(input logic [4:0] k);
    return quarter_cos((k <= 5'd16) ? 5'(5'd16 - k) : 5'(k - 5'd16));
  endfunction

  function automatic word_t sat(input logic signed [PROD_WIDTH-1:0] v);
    if (v > PROD_WIDTH'(WORD_MAX)) return WORD_MAX;
    if (v < PROD_WIDTH'(WORD_MIN)) return WORD_MIN;
    return v[WORD_WIDTH-1:0];
  endfunction

  function automatic addr_t bit_rev(input addr_t v, input logic [LOG_WIDTH-1:0] m);
    addr_t r;
    r = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(m)) r[int'(m) - 1 - b] = v[b];
    end
    return r;
  endfunction

endpackage

// File: rtl/r2fft_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples and bins.
// Depends on r2fft_pkg.
interface r2fft_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_real;
  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sample_imag;
  modport source (output valid, sample_real, sample_imag, input ready);
  modport sink   (input valid, sample_real, sample_imag, output ready);
endinterface

interface r2fft_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [r2fft_pkg::WORD_WIDTH-1:0] result_real;
  logic signed [r2fft_pkg::WORD_WIDTH-1:0] result_imag;
  logic                                   last_bin;
  modport source (output valid, result_real, result_imag, last_bin, input ready);
  modport sink   (input valid, result_real, result_imag, last_bin, output ready);
endinterface

// File: rtl/r2fft_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module r2fft_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/r2fft_bfly.sv
`timescale 1ns / 1ps
// Butterfly datapath: twiddle multiply with rounding, then add/subtract.
// Depends on r2fft_pkg.
module r2fft_bfly (
  input  logic                     clk_i,
  input  r2fft_pkg::word_t         ar_i,
  input  r2fft_pkg::word_t         ai_i,
  input  r2fft_pkg::word_t         br_i,
  input  r2fft_pkg::word_t         bi_i,
  input  r2fft_pkg::coef_t         wr_i,
  input  r2fft_pkg::coef_t         wi_i,
  input  logic                     stage_i,
  output r2fft_pkg::word_t         xr_o,
  output r2fft_pkg::word_t         xi_o,
  output r2fft_pkg::word_t         yr_o,
  output r2fft_pkg::word_t         yi_o
);
  localparam int unsigned PW = r2fft_pkg::PROD_WIDTH;
  logic signed [PW-1:0] p0_q, p1_q, sum_d;
  logic                 stage_q;
  r2fft_pkg::word_t tr_q, ti_q, t_d;

  // stage 0: one product pair; stage 1: the other pair, rotated in
  always_ff @(posedge clk_i) begin
    p0_q    <= PW'(wr_i * (stage_i ? bi_i : br_i));
    p1_q    <= PW'(wi_i * (stage_i ? br_i : bi_i));
    stage_q <= stage_i;
    if (!stage_q) tr_q <= t_d;
    else          ti_q <= t_d;
  end

  always_comb begin
    sum_d = stage_q ? (p0_q + p1_q) : (p0_q - p1_q);
    sum_d = sum_d + PW'(16384);
    t_d   = r2fft_pkg::sat(sum_d >>> 15);
  end

  assign xr_o = r2fft_pkg::sat(PW'(ar_i) + PW'(tr_q));
  assign xi_o = r2fft_pkg::sat(PW'(ai_i) + PW'(ti_q));
  assign yr_o = r2fft_pkg::sat(PW'(ar_i) - PW'(tr_q));
  assign yi_o = r2fft_pkg::sat(PW'(ai_i) - PW'(ti_q));
endmodule

// File: rtl/radix2_complex_fft_core.sv
`timescale 1ns / 1ps
// Top level of the radix-2 DIT FFT core: sequencer, sample store, output register.
// Depends on r2fft_pkg, r2fft_if, r2fft_ram and r2fft_bfly.
//
// Use: write direction (index 0) and log2_points (index 1) on the cfg port
// while idle. Send N = 2^P samples as beats on the input channel, natural
// order. After the last beat the core stops accepting, permutes the store in
// bit-reversed order and runs P stages of butterflies, then sends N bins as
// beats on the output channel, last_bin on the final one.
// Flow: loading accepts one sample per cycle while valid is held. Permutation
// reads each swapped pair and writes it back crossed, each butterfly reads both
// operands, forms the products and writes both results, all through the single
// read/write port of the sample store; emission reads each bin into the output register.
// Reset clears the sequencer and load count and restores the register
// defaults; the store keeps no reset. A stalled receiver holds the current
// bin in the output register and the sequencer waits.
module radix2_complex_fft_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [r2fft_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [r2fft_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  r2fft_in_if.sink                             in_ch,
  r2fft_out_if.source                          out_ch
);
  localparam int unsigned AW = r2fft_pkg::AW;
  localparam int unsigned WW = r2fft_pkg::WORD_WIDTH;

  typedef enum logic [3:0] {
    OP_RA = 4'b0001, OP_RB = 4'b0010, OP_WA = 4'b0100, OP_WB = 4'b1000
  } op_e;

  r2fft_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic       dir_q;
  logic [2:0] log_q;
  logic [AW:0] cnt_q, cnt_d;
  logic [AW:0] ia_q, ia_d;
  logic [2:0]  lvl_q, lvl_d;
  logic [2:0]  sub_q, sub_d;
  r2fft_pkg::addr_t pa_q, pa_d, pb_q, pb_d;
  r2fft_pkg::word_t ar_q, ai_q, br_q, bi_q;
  r2fft_pkg::word_t ar_d, ai_d, br_d, bi_d;
  logic [2:0] m;
  logic [AW:0] n;

  logic               we;
  r2fft_pkg::addr_t   addr;
  logic [2*WW-1:0]    wdata, rdata;

  r2fft_pkg::coef_t wr, wi;
  logic [4:0]       tk;
  logic             bstage;
  r2fft_pkg::word_t xr, xi, yr, yi;

  logic             ov_q, ov_d, olast_q, olast_d;
  r2fft_pkg::word_t or_q, oi_q, or_d, oi_d;

  assign m = (log_q == 3'd0) ? 3'd1 : (log_q > 3'(r2fft_pkg::LOG2_MAX_POINTS))
           ? 3'(r2fft_pkg::LOG2_MAX_POINTS) : log_q;
  assign n = (AW+1)'(1) << m;

  r2fft_ram #(.Width(2*WW), .Depth(r2fft_pkg::DEPTH)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign tk = 5'(ia_q[AW-1:0] << (3'd5 - lvl_q));
  assign wr = r2fft_pkg::cos64(tk);
  assign wi = dir_q ? r2fft_pkg::sin64(tk) : -r2fft_pkg::sin64(tk);

  r2fft_bfly u_bfly (
    .clk_i, .ar_i(ar_q), .ai_i(ai_q), .br_i(br_q), .bi_i(bi_q),
    .wr_i(wr), .wi_i(wi), .stage_i(bstage),
    .xr_o(xr), .xi_o(xi), .yr_o(yr), .yi_o(yi)
  );

  assign in_ch.ready      = (state_q == r2fft_pkg::ST_LOAD);
  assign out_ch.valid     = ov_q;
  assign out_ch.result_real = or_q;
  assign out_ch.result_imag = oi_q;
  assign out_ch.last_bin  = olast_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    cnt_d = cnt_q; ia_d = ia_q; lvl_d = lvl_q; sub_d = sub_q;
    pa_d = pa_q; pb_d = pb_q;
    ar_d = ar_q; ai_d = ai_q; br_d = br_q; bi_d = bi_q;
    ov_d = ov_q; olast_d = olast_q; or_d = or_q; oi_d = oi_q;
    we = 1'b0; addr = pa_q; wdata = {ar_q, ai_q}; bstage = 1'b0;
    if (ov_q && out_ch.ready) ov_d = 1'b0;
    unique case (state_q)
      r2fft_pkg::ST_LOAD: begin
        addr  = cnt_q[AW-1:0];
        wdata = {WW'(in_ch.sample_real), WW'(in_ch.sample_imag)};
        if (in_ch.valid) begin
          we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_d >= n) begin
            cnt_d = '0; state_d = r2fft_pkg::ST_PERM;
          end
        end
      end
      r2fft_pkg::ST_PERM: begin
        // walk i, swap with its bit reverse when i < r
        if (cnt_q == n) begin
          cnt_d = '0; lvl_d = '0; ia_d = '0; pa_d = '0;
          state_d = (m == 3'd0) ? r2fft_pkg::ST_EMIT : r2fft_pkg::ST_BFLY;
        end else if (cnt_q[AW-1:0] < r2fft_pkg::bit_rev(cnt_q[AW-1:0], m)) begin
          pa_d = cnt_q[AW-1:0];
          pb_d = r2fft_pkg::bit_rev(cnt_q[AW-1:0], m);
          sub_d = '0; ret_d = r2fft_pkg::ST_PERM; state_d = r2fft_pkg::ST_RD;
          cnt_d = cnt_q + 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      r2fft_pkg::ST_BFLY: begin
        // cnt_q: butterfly number in this level; ia_q: twiddle index j
        if (cnt_q == (n >> 1)) begin
          cnt_d = '0;
          lvl_d = lvl_q + 1'b1;
          if (lvl_d == m) begin
            state_d = r2fft_pkg::ST_EMIT;
          end
        end else begin
          ia_d = (AW+1)'(cnt_q[AW-1:0] & AW'((1 << lvl_q) - 1));
          pa_d = AW'(((cnt_q >> lvl_q) << (lvl_q + 1)) | ia_d);
          pb_d = AW'(pa_d | (AW'(1) << lvl_q));
          sub_d = '0; ret_d = r2fft_pkg::ST_BFLY; state_d = r2fft_pkg::ST_RD;
          cnt_d = cnt_q + 1'b1;
        end
      end
      r2fft_pkg::ST_RD: begin
        // sub 0: read a; 1: read b, latch a; 2: latch b
        unique case (sub_q)
          3'd0: begin addr = pa_q; sub_d = 3'd1; end
          3'd1: begin
            addr = pb_q; ar_d = rdata[2*WW-1:WW]; ai_d = rdata[WW-1:0]; sub_d = 3'd2;
          end
          default: begin
            br_d = rdata[2*WW-1:WW]; bi_d = rdata[WW-1:0]; sub_d = '0;
            state_d = r2fft_pkg::ST_WR;
          end
        endcase
      end
      r2fft_pkg::ST_WR: begin
        if (ret_q == r2fft_pkg::ST_PERM) begin
          we = 1'b1;
          if (sub_q == 3'd0) begin
            addr = pa_q; wdata = {br_q, bi_q}; sub_d = 3'd1;
          end else begin
            addr = pb_q; wdata = {ar_q, ai_q}; sub_d = '0; state_d = ret_q;
          end
        end else begin
          // sub 0: products real; 1: products imag; 2: tr; 3: ti; write x then y
          unique case (sub_q)
            3'd0: begin bstage = 1'b0; sub_d = 3'd1; end
            3'd1: begin bstage = 1'b1; sub_d = 3'd2; end
            3'd2: begin bstage = 1'b0; sub_d = 3'd3; end
            3'd3: begin bstage = 1'b1; sub_d = 3'd4; end
            3'd4: begin
              bstage = 1'b1;
              we = 1'b1; addr = pa_q; wdata = {xr, xi}; sub_d = 3'd5;
            end
            default: begin
              bstage = 1'b1;
              we = 1'b1; addr = pb_q; wdata = {yr, yi}; sub_d = '0; state_d = ret_q;
            end
          endcase
        end
      end
      r2fft_pkg::ST_EMIT: begin
        // sub 0: issue read; 1: data back, load output register when free
        addr = cnt_q[AW-1:0];
        if (sub_q == 3'd0) begin
          sub_d = 3'd1;
        end else if (!ov_d) begin
          ov_d = 1'b1;
          or_d = dir_q ? WW'($signed(rdata[2*WW-1:WW]) >>> m) : rdata[2*WW-1:WW];
          oi_d = dir_q ? WW'($signed(rdata[WW-1:0]) >>> m) : rdata[WW-1:0];
          olast_d = (cnt_q == n - 1'b1);
          sub_d = '0;
          cnt_d = cnt_q + 1'b1;
          if (cnt_d == n) begin
            cnt_d = '0; state_d = r2fft_pkg::ST_LOAD;
          end
        end
      end
      default: state_d = r2fft_pkg::ST_LOAD;
    endcase
    if (cfg_we_i && cfg_idx_i == r2fft_pkg::REG_LOG2_POINTS &&
        state_q == r2fft_pkg::ST_LOAD) cnt_d = '0;
  end

  // bstage hold: product regs take the stage of the cycle; tr latched after sub 1, ti after sub 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r2fft_pkg::ST_LOAD;
      ret_q   <= r2fft_pkg::ST_PERM;
      dir_q   <= 1'b0;
      log_q   <= 3'd6;
      cnt_q   <= '0;
      ia_q    <= '0;
      lvl_q   <= '0;
      sub_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      ia_q    <= ia_d;
      lvl_q   <= lvl_d;
      sub_q   <= sub_d;
      ov_q    <= ov_d;
      if (cfg_we_i && cfg_idx_i == r2fft_pkg::REG_DIRECTION)   dir_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_idx_i == r2fft_pkg::REG_LOG2_POINTS) log_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d; pb_q <= pb_d;
    ar_q <= ar_d; ai_q <= ai_d; br_q <= br_d; bi_q <= bi_d;
    or_q <= or_d; oi_q <= oi_d; olast_q <= olast_d;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != r2fft_pkg::ST_LOAD) |-> !in_ch.ready) else $error("input taken while busy");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ch.ready) |=> (ov_q && $stable(or_q) && $stable(oi_q)))
    else $error("output register overwritten under stall");
`endif
endmodule

// File: dv/r2fft_checker.sv
`timescale 1ns / 1ps
// Frame predictor and bin scoreboard for the radix-2 FFT core.
// Watches the config port and both channels; depends on r2fft_pkg and r2fft_if.
module r2fft_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [r2fft_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [r2fft_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [15:0]                   in_real_i,
  input  logic signed [15:0]                   in_imag_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [23:0]                   out_real_i,
  input  logic signed [23:0]                   out_imag_i,
  input  logic                                 out_last_i,
  output int                                   fail_count_o,
  output int                                   pending_bins_o
);
  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               last;
  } bin_t;

  localparam int unsigned QCOS [17] = '{32768, 32610, 32138, 31357, 30273, 28899, 27246,
    25330, 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

  bin_t           bin_queue[$];
  logic           inverse_q;
  logic [2:0]     log2_q;
  longint         frame_re[64];
  longint         frame_im[64];
  int             fill_q;

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint twiddle_cos(int k);
    k = k & 31;
    return (k <= 16) ? QCOS[k] : -longint'(QCOS[32 - k]);
  endfunction

  function automatic longint twiddle_sin(int k);
    k = k & 31;
    return QCOS[(k <= 16) ? 16 - k : k - 16];
  endfunction

  task automatic compute_frame(int m);
    int     n;
    int     r;
    int     p;
    int     half;
    longint t;
    longint wr;
    longint wi;
    longint tr;
    longint ti;
    bin_t   b;
    n = 1 << m;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int k = 0; k < m; k++) r = (r << 1) | ((i >> k) & 1);
      if (i < r) begin
        t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
        t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
      end
    end
    for (int l = 0; l < m; l++) begin
      half = 1 << l;
      for (int j = 0; j < half; j++) begin
        wr = twiddle_cos(j << (5 - l));
        wi = inverse_q ? twiddle_sin(j << (5 - l)) : -twiddle_sin(j << (5 - l));
        for (int i = j; i < n; i += 2 * half) begin
          p = i + half;
          tr = clamp24((wr * frame_re[p] - wi * frame_im[p] + 16384) >>> 15);
          ti = clamp24((wr * frame_im[p] + wi * frame_re[p] + 16384) >>> 15);
          frame_re[p] = clamp24(frame_re[i] - tr);
          frame_im[p] = clamp24(frame_im[i] - ti);
          frame_re[i] = clamp24(frame_re[i] + tr);
          frame_im[i] = clamp24(frame_im[i] + ti);
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      b.re   = inverse_q ? 24'(frame_re[k] >>> m) : 24'(frame_re[k]);
      b.im   = inverse_q ? 24'(frame_im[k] >>> m) : 24'(frame_im[k]);
      b.last = (k == n - 1);
      bin_queue.push_back(b);
    end
  endtask

  assign pending_bins_o = bin_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    int   m;
    bin_t e;
    if (!rst_ni) begin
      inverse_q    <= 1'b0;
      log2_q       <= 3'd6;
      fill_q       = 0;
      fail_count_o <= 0;
      bin_queue.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == r2fft_pkg::REG_DIRECTION) inverse_q <= cfg_data_i[0];
        else if (cfg_idx_i == r2fft_pkg::REG_LOG2_POINTS) begin
          log2_q <= cfg_data_i;
          fill_q = 0;
        end
      end
      if (in_valid_i && in_ready_i) begin
        m = (log2_q < 1) ? 1 : (log2_q > 6) ? 6 : log2_q;
        frame_re[fill_q] = in_real_i;
        frame_im[fill_q] = in_imag_i;
        fill_q++;
        if (fill_q >= (1 << m)) begin
          fill_q = 0;
          compute_frame(m);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (bin_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected bin %h %h %b",
            out_real_i, out_imag_i, out_last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = bin_queue.pop_front();
          if (e.re !== out_real_i || e.im !== out_imag_i || e.last !== out_last_i) begin
            if (fail_count_o < 10) $display("bin mismatch: exp %h %h %b got %h %h %b",
              e.re, e.im, e.last, out_real_i, out_imag_i, out_last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_radix2_complex_fft_core.sv
`timescale 1ns / 1ps
// Top of the FFT core testbench: clock, reset, config phases, sample stimulus.
// Depends on r2fft_pkg, r2fft_if, r2fft_checker and the core.
module tb_radix2_complex_fft_core;
  localparam int STALL_LIMIT = 20000;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [r2fft_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [r2fft_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i;
  int                                   fail_count;
  int                                   pending_bins;
  int                                   idle_pct;
  int                                   quiet_cycles;

  r2fft_in_if  in_ch ();
  r2fft_out_if out_ch ();

  radix2_complex_fft_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  r2fft_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_real_i(in_ch.sample_real), .in_imag_i(in_ch.sample_imag),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_real_i(out_ch.result_real), .out_imag_i(out_ch.result_imag),
    .out_last_i(out_ch.last_bin),
    .fail_count_o(fail_count), .pending_bins_o(pending_bins)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [r2fft_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [r2fft_pkg::CFG_DATA_WIDTH-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_real <= re;
    in_ch.sample_imag <= im;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_bins != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_frames(int count, int kind);
    logic signed [15:0] re;
    logic signed [15:0] im;
    for (int i = 0; i < count; i++) begin
      case (kind)
        0: begin re = 16'sh7FFF; im = 16'sh7FFF; end
        1: begin re = 16'sh8000; im = 16'sh8000; end
        2: begin re = i[0] ? 16'sh8000 : 16'sh7FFF; im = i[0] ? 16'sh7FFF : 16'sh8000; end
        default: begin re = 16'($urandom); im = 16'($urandom); end
      endcase
      send_sample(re, im);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [2:0] lg;
    logic       dir;
    int         eff;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample_real = '0;
    in_ch.sample_imag = '0;
    out_ch.ready = 1'b0;
    idle_pct     = 28;
    quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: extremes at minimum length, both directions
    write_reg(r2fft_pkg::REG_LOG2_POINTS, 3'd0);
    send_frames(2, 0);
    send_frames(2, 1);
    drain();
    write_reg(r2fft_pkg::REG_DIRECTION, 3'd1);
    send_frames(2, 2);
    drain();
    write_reg(r2fft_pkg::REG_LOG2_POINTS, 3'd7);
    write_reg(r2fft_pkg::REG_DIRECTION, 3'd0);
    send_frames(5, 3);
    // partial frame dropped by a length write
    drain();
    write_reg(r2fft_pkg::REG_LOG2_POINTS, 3'd2);
    send_frames(4, 0);
    drain();
    write_reg(r2fft_pkg::REG_LOG2_POINTS, 3'd3);
    send_frames(3, 3);
    drain();
    write_reg(r2fft_pkg::REG_LOG2_POINTS, 3'd6);
    send_frames(64, 3);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 5) ? 0 : 28;
      lg  = (ph % 6 == 5) ? 3'd6 : 3'($urandom_range(5, 1));
      dir = 1'($urandom_range(1));
      eff = (lg < 1) ? 1 : (lg > 6) ? 6 : lg;
      write_reg(r2fft_pkg::REG_DIRECTION, 3'(dir));
      write_reg(r2fft_pkg::REG_LOG2_POINTS, lg);
      send_frames((1 << eff) * (eff > 4 ? 1 : 2), $urandom_range(9) == 0 ? 2 : 3);
      drain();
    end
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
